/* src/srt_pkg.sv */
//------------------------------------------------------------------------------
// srt_pkg
// Shared types and codes of the sorted record table.
//------------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

    localparam int FUNC_W = 2;
    localparam int ID_W   = 16;
    localparam int DIST_W = 24;
    localparam int DISC_W = 16;
    localparam int POS_W  = 4;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 4;
    localparam int FILL_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
    localparam int                FUNC_READ_BIT = 1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_READ     = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
        logic [DISC_W-1:0] disc;
    } srt_entry_t;

    typedef struct packed {
        logic move;
        logic match;
        logic take;
    } srt_flags_t;

endpackage

`default_nettype wire

/* src/srt_req_if.sv */
//------------------------------------------------------------------------------
// srt_req_if
// Request channel of the sorted record table.
//------------------------------------------------------------------------------
`default_nettype none

interface srt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] rec_id;
    logic [23:0] distance;
    logic [15:0] discount;
    logic [3:0]  position;

    modport source (output valid, func, rec_id, distance, discount, position, input ready);
    modport sink (input valid, func, rec_id, distance, discount, position, output ready);
endinterface

`default_nettype wire

/* src/srt_rsp_if.sv */
//------------------------------------------------------------------------------
// srt_rsp_if
// Response channel of the sorted record table.
//------------------------------------------------------------------------------
`default_nettype none

interface srt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] out_id;
    logic [23:0] out_distance;
    logic [15:0] out_discount;
    logic [4:0]  fill;

    modport source (output valid, status, slot, out_id, out_distance, out_discount, fill,
                    input ready);
    modport sink (input valid, status, slot, out_id, out_distance, out_discount, fill,
                  output ready);
endinterface

`default_nettype wire

/* src/srt_cell.sv */
//------------------------------------------------------------------------------
// srt_cell
// One table position: holds an entry, ranks it against the key, and on an
// insert either takes its upper neighbor's entry, takes the key, or holds.
//------------------------------------------------------------------------------
`default_nettype none

module srt_cell
    import srt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       ins_en,
    input  wire srt_entry_t key,
    input  wire srt_entry_t prev_entry,
    input  wire logic       prev_move,
    input  wire logic       prev_valid,
    input  wire logic       valid,
    output srt_entry_t      entry,
    output srt_flags_t      flags
);

    srt_entry_t entry_reg;
    srt_entry_t entry_next;
    logic       dist_eq;
    logic       below;

    always_comb
    begin
        dist_eq     = (entry_reg.distance == key.distance);
        below       = (entry_reg.distance < key.distance) ||
                      (dist_eq && (entry_reg.disc > key.disc));
        flags.move  = valid && below;
        flags.match = valid && dist_eq;
        flags.take  = !prev_move && (flags.move || (!valid && prev_valid));
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ins_en)
        begin
            if (prev_move)
            begin
                entry_next = prev_entry;
            end
            else if (flags.take)
            begin
                entry_next = key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

/* src/sorted_record_table_core.sv */
//------------------------------------------------------------------------------
// sorted_record_table_core
// Table of up to CAPACITY records kept sorted by distance (descending), then
// discount (ascending), built as a row of cells that shift on insert.
//------------------------------------------------------------------------------
// Usage:
//   req: valid/ready channel carrying func, rec_id, distance, discount and
//        position. func 0 inserts, 1 finds by distance or inserts, 2 or 3
//        reads the entry at position.
//   rsp: valid/ready channel carrying exactly one result per request.
//   A transfer on req lands in a request register; once the output register
//   is free or being read, every cell ranks its entry against the key in
//   parallel, the row shifts by one where needed, and the result goes to the
//   output register, which drives rsp valid. Throughput is one request per
//   cycle while rsp does not stall, set by the single request register
//   feeding the cell row. When rsp stalls, the result holds in the output
//   register, one more request is taken into the request register, and
//   req.ready then drops until the output frees up.
//   Reset empties the table (count cleared) and needs no clearing pass;
//   entry contents are only seen below the count.
//------------------------------------------------------------------------------
`default_nettype none

module sorted_record_table_core
    import srt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    srt_req_if.sink   req,
    srt_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = CNT_W + POS_W;

    logic              pend_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [POS_W-1:0]  pos_reg;
    srt_entry_t        key_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [SLOT_W-1:0] slot_reg;
    srt_entry_t        data_reg;
    logic [FILL_W-1:0] fill_reg;

    srt_entry_t        cell_entry [CAPACITY];
    srt_flags_t        cell_flags [CAPACITY];
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] take_vec;
    logic [CAPACITY-1:0] first_vec;

    logic              exec;
    logic              is_read;
    logic              is_find;
    logic              any_match;
    logic              full;
    logic              ins_en;
    logic              rd_ok;
    srt_entry_t        rd_data;
    srt_entry_t        fd_data;
    logic [SLOT_W-1:0] fd_slot;
    logic [SLOT_W-1:0] ins_slot;
    logic [STAT_W-1:0] status_next;
    logic [SLOT_W-1:0] slot_next;
    srt_entry_t        data_next;

    assign exec      = pend_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !pend_reg || exec;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            assign valid_vec[g] = (CNT_W'(g) < count_reg);
            assign take_vec[g]  = cell_flags[g].take;
            if (g == 0)
            begin : g_head
                assign first_vec[g] = cell_flags[g].match;
                srt_cell u_cell (
                    .clk        (clk),
                    .ins_en     (ins_en),
                    .key        (key_reg),
                    .prev_entry (key_reg),
                    .prev_move  (1'b0),
                    .prev_valid (1'b1),
                    .valid      (valid_vec[g]),
                    .entry      (cell_entry[g]),
                    .flags      (cell_flags[g])
                );
            end
            else
            begin : g_body
                assign first_vec[g] = cell_flags[g].match && !cell_flags[g-1].match;
                srt_cell u_cell (
                    .clk        (clk),
                    .ins_en     (ins_en),
                    .key        (key_reg),
                    .prev_entry (cell_entry[g-1]),
                    .prev_move  (cell_flags[g-1].move),
                    .prev_valid (valid_vec[g-1]),
                    .valid      (valid_vec[g]),
                    .entry      (cell_entry[g]),
                    .flags      (cell_flags[g])
                );
            end
        end
    endgenerate

    always_comb
    begin
        rd_data  = '0;
        fd_data  = '0;
        fd_slot  = '0;
        ins_slot = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (valid_vec[k] && (CMP_W'(pos_reg) == CMP_W'(k)))
            begin
                rd_data = rd_data | cell_entry[k];
            end
            if (first_vec[k])
            begin
                fd_data = fd_data | cell_entry[k];
                fd_slot = fd_slot | SLOT_W'(k);
            end
            if (take_vec[k])
            begin
                ins_slot = ins_slot | SLOT_W'(k);
            end
        end
    end

    always_comb
    begin
        is_read   = func_reg[FUNC_READ_BIT];
        is_find   = (func_reg == FUNC_FIND);
        any_match = |first_vec;
        full      = (count_reg == CNT_W'(CAPACITY));
        rd_ok     = (CMP_W'(pos_reg) < CMP_W'(count_reg));
        ins_en    = exec && !is_read && !(is_find && any_match) && !full;
        count_next = ins_en ? count_reg + CNT_W'(1) : count_reg;

        status_next = ST_INSERTED;
        slot_next   = ins_slot;
        data_next   = '0;
        if (is_read)
        begin
            slot_next = SLOT_W'(pos_reg);
            if (rd_ok)
            begin
                status_next = ST_READ;
                data_next   = rd_data;
            end
            else
            begin
                status_next = ST_EMPTY;
            end
        end
        else if (is_find && any_match)
        begin
            status_next = ST_FOUND;
            slot_next   = fd_slot;
            data_next   = fd_data;
        end
        else if (full)
        begin
            status_next = ST_FULL;
            slot_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                pend_reg <= 1'b1;
            end
            else if (exec)
            begin
                pend_reg <= 1'b0;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg         <= req.func;
            pos_reg          <= req.position;
            key_reg.id       <= req.rec_id;
            key_reg.distance <= req.distance;
            key_reg.disc     <= req.discount;
        end
        if (exec)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            data_reg   <= data_next;
            fill_reg   <= FILL_W'(count_next);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.slot         = slot_reg;
    assign rsp.out_id       = data_reg.id;
    assign rsp.out_distance = data_reg.distance;
    assign rsp.out_discount = data_reg.disc;
    assign rsp.fill         = fill_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_one_take: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $onehot0(take_vec))
        else $error("more than one cell takes the key");

    a_one_first: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $onehot0(first_vec))
        else $error("more than one first match");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !exec |=> $stable(count_reg))
        else $error("entry count changed without a request");

endmodule

`default_nettype wire
